/* hdl/att_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// allocation tracking table. No dependencies.
`default_nettype none

package att_pkg;

  // Parameter defaults
  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int COUNTER_BITS_DEF = 48;
  localparam int SIZE_BITS_DEF    = 32;

  // Fixed field widths
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 64;
  localparam int BYTE_W     = 32;
  localparam int STATUS_W   = 2;
  localparam int CNT_OUT_W  = 48;
  localparam int LIVE_CNT_W = 32;

  localparam int IN_BITS     = CMD_W + 2 * ADDR_W + BYTE_W;
  localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS    = STATUS_W + 4 * CNT_OUT_W + LIVE_CNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_APPLIED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

  typedef struct packed {
    logic load;
    logic match;
    logic encode;
    logic decide;
    logic free_op;
    logic alloc_op;
    logic finish;
  } att_cmd_t;

  typedef struct packed {
    logic out_busy;
  } att_status_t;

endpackage

`default_nettype wire

/* hdl/att_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module att_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hdl/att_ctrl.sv */
// Sequencer for the allocation tracking table: steps each item through
// match, encode, decide, free, allocate and result. Uses att_pkg.
`default_nettype none

module att_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire att_pkg::att_status_t dp_status,
  output att_pkg::att_cmd_t         dp_cmd
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_MATCH  = 7'b0000010,
    S_ENCODE = 7'b0000100,
    S_DECIDE = 7'b0001000,
    S_FREE   = 7'b0010000,
    S_ALLOC  = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    dp_cmd     = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_next  = S_MATCH;
        end
      end
      S_MATCH: begin
        dp_cmd.match = 1'b1;
        state_next   = S_ENCODE;
      end
      S_ENCODE: begin
        dp_cmd.encode = 1'b1;
        state_next    = S_DECIDE;
      end
      S_DECIDE: begin
        dp_cmd.decide = 1'b1;
        state_next    = S_FREE;
      end
      S_FREE: begin
        dp_cmd.free_op = 1'b1;
        state_next     = S_ALLOC;
      end
      S_ALLOC: begin
        dp_cmd.alloc_op = 1'b1;
        state_next      = S_DONE;
      end
      S_DONE: begin
        // hold until the result register is free
        if (!dp_status.out_busy) begin
          dp_cmd.finish = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/att_datapath.sv */
// Datapath of the allocation tracking table: address cells with parallel
// compare, size RAM, alive bits, counters and result register.
// Uses att_pkg and att_ram.
`default_nettype none

module att_datapath #(
  parameter int TABLE_DEPTH  = att_pkg::TABLE_DEPTH_DEF,
  parameter int COUNTER_BITS = att_pkg::COUNTER_BITS_DEF,
  parameter int SIZE_BITS    = att_pkg::SIZE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire att_pkg::att_cmd_t                 dp_cmd,
  output att_pkg::att_status_t                   dp_status,
  input  wire logic [att_pkg::IN_TDATA_W-1:0]    in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [att_pkg::OUT_TDATA_W-1:0]   out_data
);

  localparam int IDX_W   = TABLE_DEPTH > 1 ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W  = $clog2(TABLE_DEPTH + 1);
  localparam int SZ_W    = SIZE_BITS < att_pkg::BYTE_W ? SIZE_BITS : att_pkg::BYTE_W;
  localparam int CNT_W   = COUNTER_BITS;
  localparam int SUM_W   = (CNT_W > SZ_W ? CNT_W : SZ_W) + 1;
  localparam int ADDR_W  = att_pkg::ADDR_W;
  localparam int CMD_W   = att_pkg::CMD_W;
  localparam int OUT_CW  = att_pkg::CNT_OUT_W;
  localparam int LC_W    = att_pkg::LIVE_CNT_W;
  localparam int PAD_W   = att_pkg::OUT_TDATA_W - att_pkg::OUT_BITS;
  localparam int A1_LO   = CMD_W;
  localparam int A2_LO   = CMD_W + ADDR_W;
  localparam int BC_LO   = CMD_W + 2 * ADDR_W;

  // Item registers
  logic [CMD_W-1:0]  cmd;
  logic [ADDR_W-1:0] addr_a;
  logic [ADDR_W-1:0] addr_b;
  logic [SZ_W-1:0]   size;

  // Table state
  logic [ADDR_W-1:0]      cam [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] alive;
  logic [USED_W-1:0]      used;

  // Lookup results
  logic [TABLE_DEPTH-1:0] match_a, match_b;
  logic [IDX_W-1:0]       slot_a, slot_b;
  logic                   found_a, found_b, alive_a;

  // Decision
  logic                            do_free, do_alloc;
  logic [att_pkg::STATUS_W-1:0]    status;

  // Counters
  logic [CNT_W-1:0] live_total;
  logic [LC_W-1:0]  live_count;
  logic [CNT_W-1:0] alloc_total;
  logic [CNT_W-1:0] freed_total;
  logic [CNT_W-1:0] peak;

  logic [SZ_W-1:0]  old_size;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;

  logic [ADDR_W-1:0] key_b;
  logic [IDX_W-1:0]  slot_a_c, slot_b_c;
  logic [IDX_W-1:0]  alloc_slot;
  logic [SUM_W-1:0]  top;
  logic [SUM_W-1:0]  live_add, alloc_add, freed_add;
  logic [CNT_W-1:0]  live_sub;
  logic [CNT_W-1:0]  peak_next;
  logic              a_nz, key_nz, room, alloc_like;

  assign key_b = (cmd == att_pkg::CMD_ALLOC) ? addr_a : addr_b;
  assign top   = SUM_W'({CNT_W{1'b1}});

  always_comb begin
    slot_a_c = '0;
    slot_b_c = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match_a[i]) slot_a_c = slot_a_c | IDX_W'(i);
      if (match_b[i]) slot_b_c = slot_b_c | IDX_W'(i);
    end
  end

  assign a_nz       = addr_a != '0;
  assign key_nz     = key_b != '0;
  assign room       = found_b || (used != USED_W'(TABLE_DEPTH));
  assign alloc_like = (cmd == att_pkg::CMD_ALLOC) || (cmd == att_pkg::CMD_REALLOC && !a_nz);
  assign alloc_slot = found_b ? slot_b : used[IDX_W-1:0];

  // Saturating adds and floored subtract
  assign live_add  = SUM_W'(live_total) + SUM_W'(size);
  assign alloc_add = SUM_W'(alloc_total) + SUM_W'(size);
  assign freed_add = SUM_W'(freed_total) + SUM_W'(old_size);
  assign live_sub  = (SUM_W'(live_total) >= SUM_W'(old_size)) ?
                     CNT_W'(SUM_W'(live_total) - SUM_W'(old_size)) : '0;
  assign peak_next = (live_total > peak) ? live_total : peak;

  assign ram_we    = dp_cmd.alloc_op && do_alloc;
  assign ram_waddr = alloc_slot;

  att_ram #(
    .WIDTH (SZ_W),
    .DEPTH (TABLE_DEPTH)
  ) u_size_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (size),
    .raddr (slot_a),
    .rdata (old_size)
  );

  // Item capture, compare, encode, decide and address cell write
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd    <= in_data[CMD_W-1:0];
      addr_a <= in_data[A1_LO +: ADDR_W];
      addr_b <= in_data[A2_LO +: ADDR_W];
      size   <= in_data[BC_LO +: SZ_W];
    end
    if (dp_cmd.match) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        match_a[i] <= (cam[i] == addr_a) && (USED_W'(i) < used);
        match_b[i] <= (cam[i] == key_b) && (USED_W'(i) < used);
      end
    end
    if (dp_cmd.encode) begin
      slot_a  <= slot_a_c;
      slot_b  <= slot_b_c;
      found_a <= |match_a;
      found_b <= |match_b;
      alive_a <= alive[slot_a_c];
    end
    if (dp_cmd.decide) begin
      do_free  <= 1'b0;
      do_alloc <= 1'b0;
      status   <= att_pkg::ST_IGNORED;
      if (alloc_like) begin
        if (key_nz && room) begin
          do_alloc <= 1'b1;
          status   <= att_pkg::ST_APPLIED;
        end else if (key_nz) begin
          status <= att_pkg::ST_REJECTED;
        end
      end else if (cmd == att_pkg::CMD_REALLOC) begin
        if (room) begin
          do_free  <= found_a && alive_a;
          do_alloc <= 1'b1;
          status   <= att_pkg::ST_APPLIED;
        end else begin
          status <= att_pkg::ST_REJECTED;
        end
      end else if (cmd == att_pkg::CMD_FREE && a_nz && found_a && alive_a) begin
        do_free <= 1'b1;
        status  <= att_pkg::ST_APPLIED;
      end
    end
    if (dp_cmd.alloc_op && do_alloc && !found_b) begin
      cam[used[IDX_W-1:0]] <= key_b;
    end
  end

  // Table control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      alive       <= '0;
      used        <= '0;
      live_total  <= '0;
      live_count  <= '0;
      alloc_total <= '0;
      freed_total <= '0;
      peak        <= '0;
    end else begin
      if (dp_cmd.free_op && do_free) begin
        alive[slot_a] <= 1'b0;
        live_total    <= live_sub;
        if (live_count != '0) live_count <= live_count - 1'b1;
        freed_total   <= (freed_add > top) ? {CNT_W{1'b1}} : freed_add[CNT_W-1:0];
      end
      if (dp_cmd.alloc_op && do_alloc) begin
        alive[alloc_slot] <= 1'b1;
        if (!found_b) used <= used + 1'b1;
        live_total  <= (live_add > top) ? {CNT_W{1'b1}} : live_add[CNT_W-1:0];
        if (live_count != '1) live_count <= live_count + 1'b1;
        alloc_total <= (alloc_add > top) ? {CNT_W{1'b1}} : alloc_add[CNT_W-1:0];
      end
      if (dp_cmd.finish) begin
        peak <= peak_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.finish) begin
      out_data <= {{PAD_W{1'b0}}, OUT_CW'(peak_next), OUT_CW'(freed_total),
                   OUT_CW'(alloc_total), live_count, OUT_CW'(live_total), status};
    end
  end

  assign dp_status.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

/* hdl/allocation_tracking_table_core.sv */
// Allocation tracking table, top level. Registered path from input accept
// to result valid: load, match, encode, decide, free, allocate, result. One
// item in flight; a stalled output holding the result register delays the
// next item. Address lookup is a registered parallel compare over all slots;
// the per-item sequence is set by the controller's seven steps. Synchronous
// active-high reset clears the alive bits, slot count and counters; no clearing pass is needed.
// Uses att_pkg, att_ctrl and att_datapath.
`default_nettype none

module allocation_tracking_table_core #(
  parameter int TABLE_DEPTH  = att_pkg::TABLE_DEPTH_DEF,
  parameter int COUNTER_BITS = att_pkg::COUNTER_BITS_DEF,
  parameter int SIZE_BITS    = att_pkg::SIZE_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // command, first_address, second_address, byte_count, zero pad
  input  wire logic [att_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // status, live byte count, live allocation count, total allocated,
  // total freed, peak live bytes, zero pad
  output logic      [att_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  att_pkg::att_cmd_t    dp_cmd;
  att_pkg::att_status_t dp_status;

  att_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  att_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .COUNTER_BITS (COUNTER_BITS),
    .SIZE_BITS    (SIZE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status),
    .in_data   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* hdl/att_checker.sv */
// Port-level checks for the allocation tracking table, bound to the top level.
// Uses att_pkg.
`default_nettype none

module att_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [att_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [1:0] pending;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_acc} - {1'b0, out_acc};
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pending != 2'd0)
    else $error("result with no item outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    in_acc |-> pending < 2'd2)
    else $error("too many items outstanding");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
    else $error("undefined status code");

  a_peak: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[225:178] >= m_axis_tdata[49:2])
    else $error("peak below live bytes");

endmodule

bind allocation_tracking_table_core att_checker u_att_checker (.*);

`default_nettype wire
